/* design/tic_pkg.sv */
// Package for the timestamp interval check: item type, calendar constants
// and the stamp field decode functions. No dependencies.
`timescale 1ns / 1ps

package tic_pkg;

  localparam int unsigned TIC_FIFO_DEPTH = 4;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_YEAR = 365;
  // year offset 100 is 2100, the only non-leap multiple of four in range
  localparam int unsigned CENTURY_OFS   = 100;

  localparam int unsigned DAYS_W = 16;   // days since 2000-01-01, plus day field
  localparam int unsigned TOD_W  = 17;   // seconds within the day, unchecked fields
  localparam int unsigned SECS_W = 33;   // seconds since 2000-01-01

  typedef struct packed {
    logic              bad_month;
    logic              no_start;
    logic [DAYS_W-1:0] days_start;
    logic [TOD_W-1:0]  tod_start;
    logic [DAYS_W-1:0] days_now;
    logic [TOD_W-1:0]  tod_now;
  } item_t;

  function automatic logic month_ok(input logic [31:0] stamp);
    logic [3:0] m;
    m = stamp[24:21];
    return m inside {[4'd1:4'd12]};
  endfunction

  function automatic logic is_leap(input logic [6:0] yy);
    return (yy[1:0] == 2'b00) && (yy != 7'(CENTURY_OFS));
  endfunction

  // days from 2000-01-01 to 1 January of year 2000+yy
  function automatic logic [DAYS_W-1:0] days_before_year(input logic [6:0] yy);
    logic [5:0] lp;
    lp = 6'((8'(yy) + 8'd3) >> 2);
    if (yy > 7'(CENTURY_OFS)) lp = lp - 6'd1;
    return DAYS_W'(DAYS_W'(yy) * DAYS_W'(DAYS_PER_YEAR)) + DAYS_W'(lp);
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && m > 4'd2) d = d + 9'd1;
    return d;
  endfunction

  // day count without the minus one of a 1-based day; it cancels in a difference
  function automatic logic [DAYS_W-1:0] stamp_days(input logic [31:0] stamp);
    return days_before_year(stamp[31:25])
         + DAYS_W'(days_before_month(stamp[24:21], is_leap(stamp[31:25])))
         + DAYS_W'(stamp[20:16]);
  endfunction

  function automatic logic [TOD_W-1:0] stamp_tod(input logic [31:0] stamp);
    return TOD_W'(TOD_W'(stamp[15:11]) * TOD_W'(SECS_PER_HOUR))
         + TOD_W'(TOD_W'(stamp[10:5]) * TOD_W'(SECS_PER_MIN))
         + TOD_W'({stamp[4:0], 1'b0});
  endfunction

endpackage

/* design/tic_front.sv */
// Front end: accepts stamp pairs, checks months and decodes each stamp into
// a day count and a time of day. Depends on tic_pkg.
`timescale 1ns / 1ps

module tic_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [31:0]    start_stamp_i,
  input  logic [31:0]    now_stamp_i,
  output logic           push_o,
  output tic_pkg::item_t item_o,
  input  logic           full_i
);
  import tic_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ready_o = !valid_r || !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = valid_r && !full_i;
  assign item_o     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b1;
    else if (push_o) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.bad_month  <= !month_ok(start_stamp_i) || !month_ok(now_stamp_i);
      item_r.no_start   <= (start_stamp_i == 32'd0);
      item_r.days_start <= stamp_days(start_stamp_i);
      item_r.tod_start  <= stamp_tod(start_stamp_i);
      item_r.days_now   <= stamp_days(now_stamp_i);
      item_r.tod_now    <= stamp_tod(now_stamp_i);
    end
  end

endmodule

/* design/tic_fifo.sv */
// Short queue of decoded items between the front and the back end.
// Depends on tic_pkg for the item type.
`timescale 1ns / 1ps

module tic_fifo #(
  parameter int unsigned DEPTH = tic_pkg::TIC_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  tic_pkg::item_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output tic_pkg::item_t rdata_o,
  output logic           empty_o
);
  import tic_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_i && !pop_i) count_nxt = count_r + 1'b1;
    else if (pop_i && !push_i) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= wdata_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a write");
`endif

endmodule

/* design/tic_back.sv */
// Back end: turns decoded stamps into seconds, takes the difference and
// compares it with the interval. Two register stages. Depends on tic_pkg.
`timescale 1ns / 1ps

module tic_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    interval_i,
  input  logic           empty_i,
  input  tic_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           in_window_o,
  output logic [15:0]    remaining_o,
  output logic           bad_month_o
);
  import tic_pkg::*;

  // seconds stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_bad_r, s1_nostart_r;
  logic [SECS_W-1:0] s1_secs_start_r, s1_secs_now_r;
  logic              s1_ready;

  // output stage
  logic              out_valid_r, out_valid_nxt;
  logic              in_window_r, bad_month_r;
  logic [15:0]       remaining_r;
  logic              out_load;

  logic signed [SECS_W:0]   elapsed;
  logic signed [SECS_W+1:0] diff;
  logic                     inw;

  assign out_load = !out_valid_r || out_ready_i;
  assign s1_ready = !s1_valid_r || out_load;
  assign pop_o    = !empty_i && s1_ready;

  assign elapsed = $signed({1'b0, s1_secs_now_r}) - $signed({1'b0, s1_secs_start_r});
  assign diff    = (SECS_W+2)'(elapsed) - $signed((SECS_W+2)'(interval_i));
  assign inw     = !s1_bad_r && !s1_nostart_r && diff[SECS_W+1];

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pop_o) s1_valid_nxt = 1'b1;
    else if (out_load) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      s1_bad_r        <= item_i.bad_month;
      s1_nostart_r    <= item_i.no_start;
      s1_secs_start_r <= SECS_W'(SECS_W'(item_i.days_start) * SECS_W'(SECS_PER_DAY))
                       + SECS_W'(item_i.tod_start);
      s1_secs_now_r   <= SECS_W'(SECS_W'(item_i.days_now) * SECS_W'(SECS_PER_DAY))
                       + SECS_W'(item_i.tod_now);
    end
    if (out_load && s1_valid_r) begin
      in_window_r <= inw;
      bad_month_r <= s1_bad_r;
      remaining_r <= inw ? (interval_i[15:0] - elapsed[15:0]) : 16'd0;
    end
  end

  assign out_valid_o = out_valid_r;
  assign in_window_o = in_window_r;
  assign remaining_o = remaining_r;
  assign bad_month_o = bad_month_r;

`ifndef SYNTHESIS
  a_bad_not_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_month_r |-> !in_window_r)
    else $error("bad month reported in window");
  a_rem_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !in_window_r |-> remaining_r == 16'd0)
    else $error("remainder not zero outside window");
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_valid_r)
    else $error("seconds stage item lost");
`endif

endmodule

/* design/timestamp_interval_check.sv */
// Timestamp interval check, top level: stream ports, register port and the
// front end, queue and back end. Depends on tic_pkg, tic_front, tic_fifo, tic_back.
//
// Use:
//   Input stream: one transaction carries a pair of packed stamps, start in
//   in_tdata[31:0] and now in in_tdata[63:32]. Result stream: one transaction
//   per input, in_window, remaining_seconds and bad_month in out_tdata.
//   interval_seconds sits at byte address 0 of the register port and should
//   be written only while no transaction is in flight.
//   A result passes through the front register, the queue, the seconds stage
//   and the output register before it is presented.
//   Throughput: one pair per cycle while the receiver does not stall; the
//   front end decodes the calendar fields, the back end does one constant
//   multiply per stamp and one subtract and compare per pair, each in its own stage.
//   When the receiver stalls the output register holds; the queue then fills
//   and in_tready drops once the front register also holds an item.
//   Synchronous reset empties all stages and clears interval_seconds to 0.
`timescale 1ns / 1ps

module timestamp_interval_check #(
  parameter int unsigned FIFO_DEPTH = tic_pkg::TIC_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // [31:0] start_stamp, [63:32] now_stamp
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [0] in_window, [16:1] remaining_seconds,
                                    // [17] bad_month, [23:18] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tic_pkg::*;

  localparam logic REG_INTERVAL = 1'b0;   // word index of interval_seconds

  logic [31:0] interval_r;
  logic        cfg_wr;

  item_t front_item, fifo_item;
  logic  push, pop, full, empty;
  logic  in_window, bad_month;
  logic [15:0] remaining;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_INTERVAL);
  assign cfg_prdata = (cfg_paddr[2] == REG_INTERVAL) ? interval_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 32'd0;
    end else if (cfg_wr) begin
      interval_r <= cfg_pwdata;
    end
  end

  tic_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid_i    (in_tvalid),
    .in_ready_o    (in_tready),
    .start_stamp_i (in_tdata[31:0]),
    .now_stamp_i   (in_tdata[63:32]),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  tic_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (fifo_item),
    .empty_o (empty)
  );

  tic_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .interval_i  (interval_r),
    .empty_i     (empty),
    .item_i      (fifo_item),
    .pop_o       (pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .in_window_o (in_window),
    .remaining_o (remaining),
    .bad_month_o (bad_month)
  );

  assign out_tdata = {6'd0, bad_month, remaining, in_window};

endmodule
